### sv/pli_pkg.sv
// Shared constants and types for the piecewise linear interpolator.
`default_nettype none
package pli_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 10;
  localparam int KNOT_W     = 2 * DATA_W;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int QSAT_W     = DATA_W + 2;

  // Largest quotient magnitude kept before the final add.
  localparam logic [QSAT_W-1:0] QUO_LIMIT = {2'b10, {DATA_W{1'b0}}};

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage
`default_nettype wire

### sv/pli_if.sv
// Valid/ready channel interfaces for query/load items and results.
`default_nettype none
interface pli_in_if
  import pli_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [IDX_W-1:0]         load_index;
  logic signed [DATA_W-1:0] knot_abscissa;
  logic signed [DATA_W-1:0] knot_ordinate;
  logic signed [DATA_W-1:0] query_abscissa;

  modport source (
    output valid, operation, load_index, knot_abscissa, knot_ordinate, query_abscissa,
    input  ready
  );
  modport sink (
    input  valid, operation, load_index, knot_abscissa, knot_ordinate, query_abscissa,
    output ready
  );
endinterface

interface pli_out_if
  import pli_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interpolated_value;
  logic                     result_valid;

  modport source (output valid, interpolated_value, result_valid, input ready);
  modport sink   (input valid, interpolated_value, result_valid, output ready);
endinterface
`default_nettype wire

### sv/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/pli_div.sv
// Iterative unsigned 64 by 32 divider, two quotient bits per cycle.
`default_nettype none
module pli_div
  import pli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [PROD_W-1:0] quotient
);

  localparam int STEPS = PROD_W / 2;
  localparam int STEP_W = $clog2(STEPS);

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [PROD_W-1:0] quo;
  } div_acc_t;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0] dsr_r, dsr_nxt;
  div_acc_t          acc_r, acc_nxt;
  div_acc_t          acc_mid, acc_end;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic div_acc_t div_step(div_acc_t a, logic [DATA_W-1:0] d);
    logic [DATA_W:0] t;
    div_acc_t        r;
    t = {a.rem, a.quo[PROD_W-1]};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      r.quo = {a.quo[PROD_W-2:0], 1'b1};
    end else begin
      r.quo = {a.quo[PROD_W-2:0], 1'b0};
    end
    r.rem = t[DATA_W-1:0];
    return r;
  endfunction

  assign acc_mid  = div_step(acc_r, dsr_r);
  assign acc_end  = div_step(acc_mid, dsr_r);
  assign done     = done_r;
  assign quotient = acc_r.quo;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dsr_nxt  = dsr_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt    = 1'b1;
      step_nxt    = '0;
      dsr_nxt     = divisor;
      acc_nxt.rem = '0;
      acc_nxt.quo = dividend;
    end else if (busy_r) begin
      acc_nxt  = acc_end;
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dsr_r <= dsr_nxt;
    acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire

### sv/piecewise_linear_interpolator_core.sv
// Piecewise linear interpolator: a 1024-entry knot table in one RAM holding
// (abscissa, ordinate) pairs, written by load items, and a query engine that
// clamps outside the table range, binary-searches for the first knot not
// below the query and interpolates in signed Q16.16. Input items are taken
// only while the engine is idle, so loads go back to back but a query holds
// the input until its hand-off. An interpolating query runs through two
// reads for the range checks, one RAM read per search probe, two reads for
// the bracketing knots, a multiply, the divider start, the wait on the
// radix-4 divider, then the final add and the hand-off. A query on an empty
// table, a clamped query and the other early exits go straight to the
// hand-off. The result sits in an output register, so the next item is taken
// while a result still waits; a second result holds the engine until the
// first one is taken. points_in_use must be written only while the block is
// idle; the block itself does not enforce it.
`default_nettype none
module piecewise_linear_interpolator_core
  import pli_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  pli_in_if.sink                in_item,
  pli_out_if.source             out_item
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_SEARCH, S_X0, S_X1, S_MUL, S_DIV_GO, S_DIV_WAIT, S_FIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]         piu_r;
  logic [CNT_W-1:0]         n_pts;
  logic [ADDR_W-1:0]        n_last;

  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] yf_r, yf_nxt;
  logic signed [DATA_W-1:0] yl_r, yl_nxt;
  logic signed [DATA_W-1:0] x0_r, x0_nxt;
  logic signed [DATA_W-1:0] y0_r, y0_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [DATA_W-1:0]        mdy_r, mdy_nxt;
  logic [DATA_W-1:0]        mdx_r, mdx_nxt;
  logic [DATA_W-1:0]        mdd_r, mdd_nxt;
  logic                     neg_r, neg_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [QSAT_W-1:0]        qsat_r, qsat_nxt;
  logic signed [DATA_W-1:0] res_val_r, res_val_nxt;
  logic                     res_flag_r, res_flag_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_val_r, out_val_nxt;
  logic                     out_flag_r, out_flag_nxt;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [KNOT_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_x, rd_y;

  logic                     div_start, div_done;
  logic [PROD_W-1:0]        div_quo;

  logic [CNT_W-1:0]         probe;
  logic signed [DATA_W:0]   dy, dx, dd;
  logic [DATA_W:0]          ady, adx, add_m;
  logic signed [QSAT_W+1:0] sq, sum;
  logic                     in_xfer;

  assign n_pts   = (piu_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : piu_r;
  assign n_last  = ADDR_W'(n_pts - 1'b1);
  assign rd_x    = ram_rdata[KNOT_W-1:DATA_W];
  assign rd_y    = ram_rdata[DATA_W-1:0];
  assign probe   = lo_r + (cnt_r >> 1);
  assign in_xfer = in_item.valid && in_item.ready;
  assign ram_we  = in_xfer && (in_item.operation == OP_LOAD);

  assign in_item.ready               = (state_r == S_IDLE);
  assign out_item.valid              = out_valid_r;
  assign out_item.interpolated_value = out_val_r;
  assign out_item.result_valid       = out_flag_r;

  pli_ram #(
    .WIDTH (KNOT_W),
    .DEPTH (MAX_POINTS)
  ) u_knots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_item.load_index)),
    .wdata ({in_item.knot_abscissa, in_item.knot_ordinate}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (mdd_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Differences from the lower knot (dy, dx, dd) and the final sum; the difference magnitudes always fit DATA_W bits.
  always_comb begin
    dy    = {rd_y[DATA_W-1], rd_y} - {y0_r[DATA_W-1], y0_r};
    dx    = {x_r[DATA_W-1], x_r} - {x0_r[DATA_W-1], x0_r};
    dd    = {rd_x[DATA_W-1], rd_x} - {x0_r[DATA_W-1], x0_r};
    ady   = dy[DATA_W] ? -dy : dy;
    adx   = dx[DATA_W] ? -dx : dx;
    add_m = dd[DATA_W] ? -dd : dd;
    sq    = neg_r ? -{2'b00, qsat_r} : {2'b00, qsat_r};
    sum   = {{(QSAT_W+2-DATA_W){y0_r[DATA_W-1]}}, y0_r} + sq;
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    yf_nxt        = yf_r;
    yl_nxt        = yl_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    lo_nxt        = lo_r;
    cnt_nxt       = cnt_r;
    mdy_nxt       = mdy_r;
    mdx_nxt       = mdx_r;
    mdd_nxt       = mdd_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    qsat_nxt      = qsat_r;
    res_val_nxt   = res_val_r;
    res_flag_nxt  = res_flag_r;
    out_val_nxt   = out_val_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    ram_raddr     = '0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_item.operation == OP_QUERY)) begin
          x_nxt = in_item.query_abscissa;
          if (n_pts == '0) begin
            res_val_nxt  = '0;
            res_flag_nxt = 1'b0;
            state_nxt    = S_DONE;
          end else begin
            res_flag_nxt = 1'b1;
            state_nxt    = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        yf_nxt = rd_y;
        if (x_r <= rd_x) begin
          res_val_nxt = rd_y;
          state_nxt   = S_DONE;
        end else begin
          ram_raddr = n_last;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        yl_nxt = rd_y;
        if (x_r >= rd_x) begin
          res_val_nxt = rd_y;
          state_nxt   = S_DONE;
        end else begin
          lo_nxt    = '0;
          cnt_nxt   = n_pts;
          ram_raddr = ADDR_W'(n_pts >> 1);
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Lower bound: advance past the probe when it is below the query.
        if (rd_x < x_r) begin
          lo_nxt  = probe + 1'b1;
          cnt_nxt = cnt_r - (cnt_r >> 1) - 1'b1;
        end else begin
          cnt_nxt = cnt_r >> 1;
        end
        if (cnt_nxt != '0) begin
          ram_raddr = ADDR_W'(lo_nxt + (cnt_nxt >> 1));
        end else if (lo_nxt == '0) begin
          res_val_nxt = yf_r;
          state_nxt   = S_DONE;
        end else if (lo_nxt >= n_pts) begin
          res_val_nxt = yl_r;
          state_nxt   = S_DONE;
        end else begin
          ram_raddr = ADDR_W'(lo_nxt - 1'b1);
          state_nxt = S_X0;
        end
      end
      S_X0: begin
        x0_nxt    = rd_x;
        y0_nxt    = rd_y;
        ram_raddr = ADDR_W'(lo_r);
        state_nxt = S_X1;
      end
      S_X1: begin
        if (rd_x == x0_r) begin
          res_val_nxt = y0_r;
          state_nxt   = S_DONE;
        end else begin
          mdy_nxt   = ady[DATA_W-1:0];
          mdx_nxt   = adx[DATA_W-1:0];
          mdd_nxt   = add_m[DATA_W-1:0];
          neg_nxt   = dy[DATA_W] ^ dx[DATA_W] ^ dd[DATA_W];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(mdy_r) * PROD_W'(mdx_r);
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          qsat_nxt  = (div_quo > PROD_W'(QUO_LIMIT)) ? QUO_LIMIT : div_quo[QSAT_W-1:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sum > (QSAT_W+2)'(VAL_MAX)) begin
          res_val_nxt = VAL_MAX;
        end else if (sum < (QSAT_W+2)'(VAL_MIN)) begin
          res_val_nxt = VAL_MIN;
        end else begin
          res_val_nxt = sum[DATA_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_item.ready) begin
          out_val_nxt   = res_val_r;
          out_flag_nxt  = res_flag_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      piu_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        piu_r <= cfg_wdata;
      end
    end
    x_r        <= x_nxt;
    yf_r       <= yf_nxt;
    yl_r       <= yl_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    lo_r       <= lo_nxt;
    cnt_r      <= cnt_nxt;
    mdy_r      <= mdy_nxt;
    mdx_r      <= mdx_nxt;
    mdd_r      <= mdd_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    qsat_r     <= qsat_nxt;
    res_val_r  <= res_val_nxt;
    res_flag_r <= res_flag_nxt;
    out_val_r  <= out_val_nxt;
    out_flag_r <= out_flag_nxt;
  end

endmodule
`default_nettype wire
